[hw/rtl/pqncs_pkg.sv]
// ----------------------------------------------------------------------------
// pqncs_pkg
// Shared constants, types and codes for the product-quantization
// nearest-codeword search unit.
// ----------------------------------------------------------------------------
package pqncs_pkg;

    // Geometry of the codebook.
    localparam int NUM_SUBSPACES = 4;
    localparam int CODEWORDS     = 256;
    localparam int SUB_DIM       = 16;

    // Field widths fixed by the interface.
    localparam int FUNC_W    = 1;
    localparam int SUB_W     = 2;
    localparam int SLOT_W    = 8;
    localparam int WORD_W    = 64;
    localparam int INDEX_W   = 8;
    localparam int ELEM_W    = 8;
    localparam int ZP_W      = 8;
    localparam int VEC_W     = SUB_DIM * ELEM_W;

    // Store addressing.
    localparam int ENTRIES   = NUM_SUBSPACES * CODEWORDS;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int IDX_W     = (CODEWORDS > 1) ? $clog2(CODEWORDS) : 1;

    // Arithmetic widths: 8x8 products, four-element partial sums, full dot
    // product, squared norm (at most 16*128*128) and the distance.
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int GROUPS    = 4;
    localparam int GROUP_SZ  = SUB_DIM / GROUPS;
    localparam int PART_W    = PROD_W + $clog2(GROUP_SZ);
    localparam int DOT_W     = PART_W + $clog2(GROUPS);
    localparam int NORM_W    = 19;
    localparam int DIST_W    = DOT_W + 2;

    // Reset value of the zero point register.
    localparam logic [ZP_W-1:0] ZP_RESET = 8'd128;

    // Operation codes of the func field.
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [DIST_W-1:0] dist_t;

    // Control state of the top-level sequencer.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_RESULT
    } state_t;

    // Tag that travels down the pipeline next to each codeword.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

    // Status returned by the merging stage.
    typedef struct packed {
        logic             dot_valid;
        dot_t             dot;
        logic             done;
        logic [IDX_W-1:0] best_idx;
    } merge_status_t;

endpackage

[hw/rtl/pqncs_lane.sv]
// ----------------------------------------------------------------------------
// pqncs_lane
// One multiply lane: a signed 8x8 product with a registered result.
// ----------------------------------------------------------------------------
module pqncs_lane (
    input  logic            aclk,
    input  pqncs_pkg::elem_t a_in,
    input  pqncs_pkg::elem_t b_in,
    output pqncs_pkg::prod_t prod
);
    import pqncs_pkg::*;

    prod_t prod_reg;

    // The product is registered before it reaches the adder tree.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a_in) * PROD_W'(b_in);
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/pqncs_merge.sv]
// ----------------------------------------------------------------------------
// pqncs_merge
// Merging stage: sums the lane products, forms the distance and keeps the
// running minimum over one scan.
// ----------------------------------------------------------------------------
module pqncs_merge (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pqncs_pkg::prod_t          prod [pqncs_pkg::SUB_DIM],
    input  logic [pqncs_pkg::NORM_W-1:0] norm_in,
    input  pqncs_pkg::tag_t           tag_in,
    output pqncs_pkg::merge_status_t  status
);
    import pqncs_pkg::*;

    part_t              part_reg [GROUPS];
    tag_t               tag1_reg;
    logic [NORM_W-1:0]  norm1_reg;

    dot_t               dot_reg;
    tag_t               tag2_reg;
    logic [NORM_W-1:0]  norm2_reg;

    dist_t              best_dist_reg;
    dist_t              best_dist_next;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [IDX_W-1:0]   best_idx_next;
    logic               done_reg;
    dist_t              cur_dist;

    // First tree level: four partial sums of four products each.
    always_ff @(posedge aclk) begin
        for (int g = 0; g < GROUPS; g++) begin
            part_t acc;
            acc = '0;
            for (int j = 0; j < GROUP_SZ; j++) begin
                acc = acc + PART_W'(prod[g * GROUP_SZ + j]);
            end
            part_reg[g] <= acc;
        end
        norm1_reg <= norm_in;
    end

    // Second tree level: the full dot product.
    always_ff @(posedge aclk) begin
        dot_t acc;
        acc = '0;
        for (int g = 0; g < GROUPS; g++) begin
            acc = acc + DOT_W'(part_reg[g]);
        end
        dot_reg   <= acc;
        norm2_reg <= norm1_reg;
    end

    // Tag valid bits follow the data through both tree levels.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    // Distance less the query norm: norm minus twice the dot product.
    assign cur_dist = signed'(DIST_W'({1'b0, norm2_reg})) - (DIST_W'(dot_reg) <<< 1);

    // Strict compare keeps the lowest index on equal distances.
    always_comb begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (tag2_reg.valid && (tag2_reg.first || (cur_dist < best_dist_reg))) begin
            best_dist_next = cur_dist;
            best_idx_next  = tag2_reg.idx;
        end
    end

    always_ff @(posedge aclk) begin
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= tag2_reg.valid && tag2_reg.last;
        end
    end

    assign status.dot_valid = tag2_reg.valid;
    assign status.dot       = dot_reg;
    assign status.done      = done_reg;
    assign status.best_idx  = best_idx_reg;

endmodule

[hw/rtl/pq_nearest_codeword_search_unit.sv]
// ----------------------------------------------------------------------------
// pq_nearest_codeword_search_unit
// Product-quantization encoder: codebook loading and nearest-codeword search
// over sixteen parallel multiply lanes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) carries load and query items. A load writes one
//   16-element int8 codeword into the codebook store and records its squared
//   norm; it gives no result. A query carries 16 unsigned latent bytes; the
//   zero point is subtracted and all codewords of the subspace are searched.
//   The result channel (m_*) returns the nearest index and the subspace.
//   Throughput: one item at a time. A query scans one codeword per cycle
//   through the codebook memory read port. A load forms its squared norm
//   in the lanes; a load to a slot or subspace out of range is accepted
//   and dropped. A query to a subspace out of range skips the scan and
//   returns index 0. The result sits in an output register; if the
//   receiver stalls, the next item is still accepted, and a later result
//   waits inside until the output register is free. Reset restores the
//   zero point to 128 and empties the pipeline; the stores are undefined
//   until each entry is loaded. The user must write the zero point through
//   cfg_we/cfg_wdata only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module pq_nearest_codeword_search_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pqncs_pkg::ZP_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pqncs_pkg::FUNC_W-1:0]      s_func,
    input  logic [pqncs_pkg::SUB_W-1:0]       s_subspace,
    input  logic [pqncs_pkg::SLOT_W-1:0]      s_codeword_slot,
    input  logic [pqncs_pkg::WORD_W-1:0]      s_data_low,
    input  logic [pqncs_pkg::WORD_W-1:0]      s_data_high,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pqncs_pkg::INDEX_W-1:0]     m_best_index,
    output logic [pqncs_pkg::SUB_W-1:0]       m_subspace_echo
);
    import pqncs_pkg::*;

    // Stores.
    logic [VEC_W-1:0]   codebook_mem [ENTRIES];
    logic [NORM_W-1:0]  norm_mem     [ENTRIES];

    state_t             state_reg, state_next;
    logic [ZP_W-1:0]    zero_point_reg;

    logic               s_accept;
    logic               sub_ok, slot_ok;
    logic [ADDR_W-1:0]  in_addr;
    logic [VEC_W-1:0]   in_data;
    logic [VEC_W-1:0]   z_next;

    logic [VEC_W-1:0]   z_reg;
    logic [VEC_W-1:0]   ld_data_reg;
    logic               mode_load_reg;
    logic [SUB_W-1:0]   sub_reg;
    logic [ADDR_W-1:0]  norm_addr_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               scan_last;

    logic [VEC_W-1:0]   cb_rd_reg;
    logic [NORM_W-1:0]  norm_rd_reg;
    logic [NORM_W-1:0]  norm_d_reg;

    tag_t               tag0;
    tag_t               tag1_reg;
    tag_t               tag2_reg;

    elem_t              lane_a [SUB_DIM];
    elem_t              lane_b [SUB_DIM];
    prod_t              lane_prod [SUB_DIM];
    merge_status_t      merge_status;

    logic [INDEX_W-1:0] res_index_reg;
    logic               out_load;
    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_best_index_reg;
    logic [SUB_W-1:0]   m_subspace_echo_reg;

    // Input decode.
    assign s_accept = s_valid && s_ready;
    assign sub_ok   = ({1'b0, s_subspace} < (SUB_W + 1)'(NUM_SUBSPACES));
    assign slot_ok  = ({1'b0, s_codeword_slot} < (SLOT_W + 1)'(CODEWORDS));
    assign in_addr  = ADDR_W'(int'(s_subspace) * CODEWORDS + int'(s_codeword_slot));
    assign in_data  = {s_data_high, s_data_low};

    // Latent bytes less the zero point, wrapping to eight bits.
    always_comb begin
        for (int d = 0; d < SUB_DIM; d++) begin
            z_next[d * ELEM_W +: ELEM_W] = in_data[d * ELEM_W +: ELEM_W] - zero_point_reg;
        end
    end

    // Scan address and end of scan.
    assign rd_addr   = ADDR_W'(int'(sub_reg) * CODEWORDS + int'(scan_idx_reg));
    assign scan_last = (scan_idx_reg == IDX_W'(CODEWORDS - 1));

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_point_reg <= ZP_RESET;
        end else if (cfg_we) begin
            zero_point_reg <= cfg_wdata;
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake and issue of codewords into the lanes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        tag0       = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_LOAD) begin
                        if (sub_ok && slot_ok) begin
                            tag0.valid = 1'b1;
                            tag0.first = 1'b1;
                            tag0.last  = 1'b1;
                            state_next = S_WAIT;
                        end
                    end else begin
                        state_next = sub_ok ? S_SCAN : S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                tag0.valid = 1'b1;
                tag0.first = (scan_idx_reg == '0);
                tag0.last  = scan_last;
                tag0.idx   = scan_idx_reg;
                if (scan_last) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (merge_status.done) begin
                    state_next = mode_load_reg ? S_IDLE : S_RESULT;
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Item registers and scan counter.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            z_reg         <= z_next;
            ld_data_reg   <= in_data;
            mode_load_reg <= (s_func == FUNC_LOAD);
            sub_reg       <= s_subspace;
            norm_addr_reg <= in_addr;
            scan_idx_reg  <= '0;
        end else if (state_reg == S_SCAN) begin
            scan_idx_reg  <= scan_idx_reg + 1'b1;
        end
    end

    // Result held until the output register is free.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_index_reg <= '0;
        end else if ((state_reg == S_WAIT) && merge_status.done) begin
            res_index_reg <= INDEX_W'(merge_status.best_idx);
        end
    end

    // Codebook memory: written by loads, read once per cycle by the scan.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_func == FUNC_LOAD) && sub_ok && slot_ok) begin
            codebook_mem[in_addr] <= in_data;
        end
        cb_rd_reg <= codebook_mem[rd_addr];
    end

    // Norm memory: written when the lanes finish a load's squared norm.
    always_ff @(posedge aclk) begin
        if (merge_status.dot_valid && mode_load_reg) begin
            norm_mem[norm_addr_reg] <= NORM_W'(merge_status.dot);
        end
        norm_rd_reg <= norm_mem[rd_addr];
        norm_d_reg  <= norm_rd_reg;
    end

    // Tags follow the memory read and the lane product registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_reg;
        end
    end

    // Lane operands: a load squares its own elements, a query multiplies the
    // shifted latent by the stored codeword.
    always_comb begin
        for (int d = 0; d < SUB_DIM; d++) begin
            lane_a[d] = mode_load_reg ? elem_t'(ld_data_reg[d * ELEM_W +: ELEM_W])
                                      : elem_t'(z_reg[d * ELEM_W +: ELEM_W]);
            lane_b[d] = mode_load_reg ? elem_t'(ld_data_reg[d * ELEM_W +: ELEM_W])
                                      : elem_t'(cb_rd_reg[d * ELEM_W +: ELEM_W]);
        end
    end

    for (genvar d = 0; d < SUB_DIM; d++) begin : g_lane
        pqncs_lane u_lane (
            .aclk (aclk),
            .a_in (lane_a[d]),
            .b_in (lane_b[d]),
            .prod (lane_prod[d])
        );
    end

    pqncs_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .prod    (lane_prod),
        .norm_in (norm_d_reg),
        .tag_in  (tag2_reg),
        .status  (merge_status)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_best_index_reg    <= res_index_reg;
            m_subspace_echo_reg <= sub_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_best_index    = m_best_index_reg;
    assign m_subspace_echo = m_subspace_echo_reg;

    // The merge stage finishes a scan only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        merge_status.done |-> (state_reg == S_WAIT))
        else $error("merge finished outside the wait state");

    // No codeword is in flight when a new item can be accepted.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!tag1_reg.valid && !tag2_reg.valid && !merge_status.dot_valid))
        else $error("pipeline not empty while accepting an item");

    // A new result appears only out of the result state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside the result state");

    // A load never issues a scan of the codebook.
    a_load_no_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !mode_load_reg)
        else $error("scan running for a load item");

endmodule

[dv/pq_nearest_codeword_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// pq_nearest_codeword_search_unit_tb
// Self-checking testbench for the nearest-codeword search unit. The whole
// codebook is loaded first. Directed queries then cover extreme latents,
// exact matches, equal distances and both ends of the zero point. After that
// come random mixes of codeword reloads and queries under varied idling and
// a long result stall. A shadow copy of the codebook predicts every index.
// ----------------------------------------------------------------------------
import pqncs_pkg::*;

typedef struct packed {
    logic [INDEX_W-1:0] best_index;
    logic [SUB_W-1:0]   subspace;
} pq_result_t;

// Shadow of the codebook, the norms and the zero point. It predicts the
// index that each query returns and checks the results in order.
class pq_codebook_shadow;
    localparam int BEST_INIT = 'h7FFF_FFFF;

    logic [VEC_W-1:0] cw_mem [ENTRIES];
    int               norm_mem [ENTRIES];
    logic [ZP_W-1:0]  zero_point;
    pq_result_t       expected_index_q [$];
    int               error_count;

    function new();
        zero_point  = ZP_RESET;
        error_count = 0;
        for (int e = 0; e < ENTRIES; e++) begin
            cw_mem[e]   = '0;
            norm_mem[e] = 0;
        end
    endfunction

    // Sum of the squares of the sixteen int8 elements.
    function int squared_norm(logic [VEC_W-1:0] cw);
        elem_t c;
        int    acc;
        acc = 0;
        for (int d = 0; d < SUB_DIM; d++) begin
            c = cw[d*ELEM_W +: ELEM_W];
            acc += int'(c) * int'(c);
        end
        return acc;
    endfunction

    // Index of the least norm - 2 * dot over the subspace. The comparison is
    // strict, so on equal distances the lowest index wins.
    function logic [INDEX_W-1:0] nearest_index(logic [SUB_W-1:0] sub,
                                               logic [VEC_W-1:0] latent);
        elem_t              z [SUB_DIM];
        elem_t              c;
        int                 best_distance;
        int                 distance;
        int                 dot;
        int                 entry;
        logic [INDEX_W-1:0] best_k;
        best_k = '0;
        if (sub >= NUM_SUBSPACES) begin
            return best_k;
        end
        best_distance = BEST_INIT;
        // The zero point is taken off in eight bits and the byte read as int8.
        for (int d = 0; d < SUB_DIM; d++) begin
            z[d] = latent[d*ELEM_W +: ELEM_W] - zero_point;
        end
        for (int k = 0; k < CODEWORDS; k++) begin
            entry = sub * CODEWORDS + k;
            dot   = 0;
            for (int d = 0; d < SUB_DIM; d++) begin
                c = cw_mem[entry][d*ELEM_W +: ELEM_W];
                dot += int'(z[d]) * int'(c);
            end
            distance = norm_mem[entry] - 2 * dot;
            if (distance < best_distance) begin
                best_distance = distance;
                best_k        = INDEX_W'(k);
            end
        end
        return best_k;
    endfunction

    // Called for every accepted input item.
    function void note_item(logic [FUNC_W-1:0] func, logic [SUB_W-1:0] sub,
                            logic [SLOT_W-1:0] slot, logic [VEC_W-1:0] data);
        pq_result_t res;
        int         entry;
        if (func == FUNC_LOAD) begin
            if (sub < NUM_SUBSPACES && slot < CODEWORDS) begin
                entry           = sub * CODEWORDS + slot;
                cw_mem[entry]   = data;
                norm_mem[entry] = squared_norm(data);
            end
        end else begin
            res.best_index = nearest_index(sub, data);
            res.subspace   = sub;
            expected_index_q.push_back(res);
        end
    endfunction

    // Called for every accepted result item.
    function void check_index(logic [INDEX_W-1:0] best_index,
                              logic [SUB_W-1:0] subspace_echo);
        pq_result_t exp_res;
        if (expected_index_q.size() == 0) begin
            $error("unexpected result item: best_index %0d subspace_echo %0d",
                   best_index, subspace_echo);
            error_count++;
            return;
        end
        exp_res = expected_index_q.pop_front();
        if (best_index !== exp_res.best_index) begin
            $error("best_index mismatch: expected %0d, actual %0d",
                   exp_res.best_index, best_index);
            error_count++;
        end
        if (subspace_echo !== exp_res.subspace) begin
            $error("subspace_echo mismatch: expected %0d, actual %0d",
                   exp_res.subspace, subspace_echo);
            error_count++;
        end
    endfunction
endclass

module pq_nearest_codeword_search_unit_tb;

    localparam int CYCLE_LIMIT   = 2_000_000;
    // Covers a full scan of one subspace plus the output register.
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 2500;
    localparam int PHASE_ITEMS   = 300;

    typedef enum int {CW_RANDOM, CW_SMALL, CW_EXTREME, CW_COPY} cw_kind_t;
    typedef enum int {LAT_RANDOM, LAT_NEAR, LAT_EXTREME} latent_kind_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [ZP_W-1:0]     cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func;
    logic [SUB_W-1:0]    s_subspace;
    logic [SLOT_W-1:0]   s_codeword_slot;
    logic [WORD_W-1:0]   s_data_low;
    logic [WORD_W-1:0]   s_data_high;
    logic                m_valid;
    logic                m_ready;
    logic [INDEX_W-1:0]  m_best_index;
    logic [SUB_W-1:0]    m_subspace_echo;

    int send_idle_pct  = 25;
    int recv_idle_pct  = 88;
    int recv_hold_left = 0;
    int cycle_count    = 0;

    pq_codebook_shadow codebook_shadow;

    pq_nearest_codeword_search_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_subspace      (s_subspace),
        .s_codeword_slot (s_codeword_slot),
        .s_data_low      (s_data_low),
        .s_data_high     (s_data_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_best_index    (m_best_index),
        .m_subspace_echo (m_subspace_echo)
    );

    // Clock, period 20.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off while it is counted down.
    always @(posedge aclk) begin
        if (recv_hold_left > 0) begin
            m_ready <= 1'b0;
            recv_hold_left = recv_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both handshakes are sampled at the edge that completes them.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            codebook_shadow.note_item(s_func, s_subspace, s_codeword_slot,
                                      {s_data_high, s_data_low});
        end
        if (aresetn && m_valid && m_ready) begin
            codebook_shadow.check_index(m_best_index, m_subspace_echo);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pq_nearest_codeword_search_unit regression: fail");
            $finish;
        end
    end

    function automatic logic [VEC_W-1:0] random_vec();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Latent bytes that land exactly on a codeword once the offset is removed.
    function automatic logic [VEC_W-1:0] latent_for(logic [VEC_W-1:0] cw,
                                                    logic [ZP_W-1:0] offset);
        logic [VEC_W-1:0] lat;
        for (int d = 0; d < SUB_DIM; d++) begin
            lat[d*ELEM_W +: ELEM_W] = cw[d*ELEM_W +: ELEM_W] + offset;
        end
        return lat;
    endfunction

    function automatic logic [VEC_W-1:0] make_codeword(logic [SUB_W-1:0] sub);
        logic [VEC_W-1:0] cw;
        cw_kind_t         kind;
        int               pick;
        logic             mixed;
        pick  = $urandom_range(99);
        kind  = (pick < 40) ? CW_RANDOM : (pick < 60) ? CW_SMALL :
                (pick < 75) ? CW_EXTREME : CW_COPY;
        cw    = random_vec();
        mixed = $urandom_range(1);
        case (kind)
            CW_SMALL: begin
                for (int d = 0; d < SUB_DIM; d++) begin
                    cw[d*ELEM_W +: ELEM_W] = ELEM_W'($urandom_range(8) - 4);
                end
            end
            CW_EXTREME: begin
                // Element 0 at -128 and the rest at 127, the reverse, or a random mix.
                for (int d = 0; d < SUB_DIM; d++) begin
                    cw[d*ELEM_W +: ELEM_W] = (mixed ? $urandom_range(1) : cw[0]) ?
                                             8'h80 : 8'h7F;
                end
            end
            CW_COPY: begin
                // Duplicates make equal distances common.
                cw = codebook_shadow.cw_mem[sub * CODEWORDS
                                            + $urandom_range(CODEWORDS - 1)];
            end
            default: begin
            end
        endcase
        return cw;
    endfunction

    function automatic logic [VEC_W-1:0] make_latent(logic [SUB_W-1:0] sub);
        logic [VEC_W-1:0] lat;
        logic [VEC_W-1:0] cw;
        logic [ZP_W-1:0]  zp;
        logic [ELEM_W-1:0] fill_byte;
        latent_kind_t     kind;
        int               pick;
        logic             mixed;
        zp    = codebook_shadow.zero_point;
        pick  = $urandom_range(99);
        kind  = (pick < 45) ? LAT_RANDOM : (pick < 85) ? LAT_NEAR : LAT_EXTREME;
        lat   = random_vec();
        mixed = $urandom_range(1);
        case (kind)
            LAT_NEAR: begin
                // A stored codeword plus a little noise.
                cw  = codebook_shadow.cw_mem[sub * CODEWORDS
                                             + $urandom_range(CODEWORDS - 1)];
                lat = latent_for(cw, zp);
                for (int d = 0; d < SUB_DIM; d++) begin
                    lat[d*ELEM_W +: ELEM_W] += ELEM_W'($urandom_range(4) - 2);
                end
            end
            LAT_EXTREME: begin
                pick      = $urandom_range(2);
                fill_byte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : zp;
                for (int d = 0; d < SUB_DIM; d++) begin
                    lat[d*ELEM_W +: ELEM_W] = (mixed && $urandom_range(1)) ?
                                              ~fill_byte : fill_byte;
                end
            end
            default: begin
            end
        endcase
        return lat;
    endfunction

    // Offers one item after a random gap and returns at the accepting edge.
    // Valid stays high into the next item unless that item starts with a gap.
    task automatic send_item(input logic [FUNC_W-1:0] func,
                             input logic [SUB_W-1:0] sub,
                             input logic [SLOT_W-1:0] slot,
                             input logic [VEC_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= func;
        s_subspace      <= sub;
        s_codeword_slot <= slot;
        s_data_low      <= data[WORD_W-1:0];
        s_data_high     <= data[VEC_W-1:WORD_W];
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Waits until every expected index has arrived and any load has retired.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (codebook_shadow.expected_index_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_zero_point(input logic [ZP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        codebook_shadow.zero_point = value;
    endtask

    // Loads every slot before any query. Subspace 0 opens with the extreme
    // codewords, subspace 3 repeats sixteen patterns so ties are frequent.
    task automatic fill_codebook();
        logic [VEC_W-1:0] cw;
        logic [SUB_W-1:0] sub;
        for (int s = 0; s < NUM_SUBSPACES; s++) begin
            sub = SUB_W'(s);
            for (int k = 0; k < CODEWORDS; k++) begin
                cw = make_codeword(sub);
                if (s == 0 && k == 0) begin
                    cw = {SUB_DIM{8'h80}};
                end else if (s == 0 && k == 1) begin
                    cw = {SUB_DIM{8'h7F}};
                end else if (s == 0 && k == 2) begin
                    cw = '0;
                end else if (s == 0 && k == 3) begin
                    cw = {(SUB_DIM / 2){16'h807F}};
                end else if (s == 0) begin
                    cw = random_vec();
                end else if (s == NUM_SUBSPACES - 1 && k >= 16) begin
                    cw = codebook_shadow.cw_mem[s * CODEWORDS + k % 16];
                end
                send_item(FUNC_LOAD, sub, SLOT_W'(k), cw);
            end
        end
    endtask

    // Random mix of reloads and queries.
    task automatic run_random(input int count);
        logic [SUB_W-1:0] sub;
        for (int n = 0; n < count; n++) begin
            sub = SUB_W'($urandom_range(NUM_SUBSPACES - 1));
            if ($urandom_range(99) < 35) begin
                send_item(FUNC_LOAD, sub, SLOT_W'($urandom_range(CODEWORDS - 1)),
                          make_codeword(sub));
            end else begin
                send_item(FUNC_QUERY, sub, SLOT_W'($urandom_range(255)),
                          make_latent(sub));
            end
        end
    endtask

    initial begin
        codebook_shadow = new();
        aresetn         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_func          <= FUNC_LOAD;
        s_subspace      <= '0;
        s_codeword_slot <= '0;
        s_data_low      <= '0;
        s_data_high     <= '0;
        m_ready         <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        fill_codebook();

        // Directed queries at the reset zero point of 128.
        send_item(FUNC_QUERY, 2'd0, 8'h00, '0);
        send_item(FUNC_QUERY, 2'd0, 8'hFF, '1);
        send_item(FUNC_QUERY, 2'd0, 8'h00, {SUB_DIM{8'h80}});
        send_item(FUNC_QUERY, 2'd1, 8'h00,
                  latent_for(codebook_shadow.cw_mem[CODEWORDS + 100], ZP_RESET));
        send_item(FUNC_QUERY, 2'd3, 8'h00,
                  latent_for(codebook_shadow.cw_mem[3 * CODEWORDS + 200], ZP_RESET));
        send_item(FUNC_QUERY, 2'd2, 8'h00, {SUB_DIM{8'h80}});
        // Equal distances: duplicate the extreme and the zero codewords.
        send_item(FUNC_LOAD, 2'd0, 8'hFF, {SUB_DIM{8'h80}});
        send_item(FUNC_LOAD, 2'd0, 8'h01, '0);
        send_item(FUNC_QUERY, 2'd0, 8'h00, '0);
        send_item(FUNC_QUERY, 2'd0, 8'h00, {SUB_DIM{8'h80}});

        // Zero point at its low end.
        wait_quiet();
        write_zero_point(8'd0);
        send_item(FUNC_QUERY, 2'd1, 8'h00, '0);
        send_item(FUNC_QUERY, 2'd1, 8'h00, '1);
        send_item(FUNC_QUERY, 2'd1, 8'h00, {SUB_DIM{8'h7F}});
        send_item(FUNC_QUERY, 2'd1, 8'h00, {SUB_DIM{8'h80}});

        // Zero point at its high end.
        wait_quiet();
        write_zero_point(8'd255);
        send_item(FUNC_QUERY, 2'd2, 8'h00, '1);
        send_item(FUNC_QUERY, 2'd2, 8'h00, '0);
        send_item(FUNC_QUERY, 2'd3, 8'h00,
                  latent_for(codebook_shadow.cw_mem[3 * CODEWORDS + 5], 8'd255));

        // Random phase with a slow receiver.
        wait_quiet();
        write_zero_point(ZP_W'($urandom_range(255)));
        run_random(PHASE_ITEMS);

        // Random phase with a slow sender.
        wait_quiet();
        write_zero_point(ZP_W'($urandom_range(255)));
        send_idle_pct = 88;
        recv_idle_pct = 25;
        run_random(PHASE_ITEMS);

        // Random phase at full rate, opening with a long result stall.
        wait_quiet();
        write_zero_point(ZP_RESET);
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        recv_hold_left = HOLD_CYCLES;
        run_random(PHASE_ITEMS);

        wait_quiet();
        if (codebook_shadow.error_count == 0) begin
            $display("pq_nearest_codeword_search_unit regression: pass");
        end else begin
            $display("pq_nearest_codeword_search_unit regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pqncs_pkg.sv
hw/rtl/pqncs_lane.sv
hw/rtl/pqncs_merge.sv
hw/rtl/pq_nearest_codeword_search_unit.sv
dv/pq_nearest_codeword_search_unit_tb.sv
